// ===== sv/packet_threat_classifier_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PACKET_THREAT_CLASSIFIER_DEFINES_SVH
`define PACKET_THREAT_CLASSIFIER_DEFINES_SVH

// Concurrent assertion on a given clock, off while reset is low.
`define PTC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PTC_ASSERT(label, prop, msg) \
  `PTC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, codes and lookup functions of the packet threat classifier.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned TABLES = 4;
  localparam int unsigned T_SCAN  = 0;
  localparam int unsigned T_LOGIN = 1;
  localparam int unsigned T_FLOOD = 2;
  localparam int unsigned T_SYN   = 3;

  localparam logic [2:0] CFG_SCAN_WINDOW = 3'd0;
  localparam logic [2:0] CFG_SYN_WINDOW  = 3'd1;
  localparam logic [2:0] CFG_SCAN_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_LOGIN_LIMIT = 3'd3;
  localparam logic [2:0] CFG_FLOOD_LIMIT = 3'd4;
  localparam logic [2:0] CFG_SYN_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_ICMP_LIMIT  = 3'd6;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_SCAN  = 3'd1;
  localparam logic [2:0] KIND_BRUTE = 3'd2;
  localparam logic [2:0] KIND_FLOOD = 3'd3;
  localparam logic [2:0] KIND_NULL  = 3'd4;
  localparam logic [2:0] KIND_SYN   = 3'd5;
  localparam logic [2:0] KIND_PORT  = 3'd6;
  localparam logic [2:0] KIND_ICMP  = 3'd7;

  localparam logic [2:0] LVL_NONE     = 3'd0;
  localparam logic [2:0] LVL_MEDIUM   = 3'd3;
  localparam logic [2:0] LVL_HIGH     = 3'd4;
  localparam logic [2:0] LVL_CRITICAL = 3'd5;

  localparam logic [6:0] CONF_SCAN  = 7'd85;
  localparam logic [6:0] CONF_BRUTE = 7'd90;
  localparam logic [6:0] CONF_FLOOD = 7'd95;
  localparam logic [6:0] CONF_NULL  = 7'd80;
  localparam logic [6:0] CONF_SYN   = 7'd90;
  localparam logic [6:0] CONF_PORT  = 7'd70;
  localparam logic [6:0] CONF_ICMP  = 7'd88;

  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

  localparam logic [15:0] SCAN_WINDOW_RST = 16'd60;
  localparam logic [15:0] SYN_WINDOW_RST  = 16'd10;
  localparam logic [4:0]  SCAN_LIMIT_RST  = 5'd20;
  localparam logic [15:0] LOGIN_LIMIT_RST = 16'd30;
  localparam logic [15:0] FLOOD_LIMIT_RST = 16'd500;
  localparam logic [15:0] SYN_LIMIT_RST   = 16'd100;
  localparam logic [15:0] ICMP_LIMIT_RST  = 16'd100;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_SRD, ST_SCMP, ST_SLOT, ST_ERD, ST_EUPD,
    ST_PCHK, ST_PRD, ST_PCMP, ST_FIN
  } ptc_state_e;

  typedef struct packed {
    logic accept;
    logic srch_cmp;
    logic rd_slot;
    logic slot_fix;
    logic ent_upd;
    logic port_cmp;
    logic fin;
  } ptc_ctl_t;

  typedef struct packed {
    logic srch_empty;
    logic srch_last;
    logic port_skip;
    logic port_last;
    logic out_free;
  } ptc_stat_t;

  function automatic logic login_port_hit(input logic [15:0] p);
    return (p == 16'd22) || (p == 16'd23) || (p == 16'd21) || (p == 16'd3389) ||
           (p == 16'd5900) || (p == 16'd1433);
  endfunction

  function automatic logic is_bad_port(input logic [15:0] p);
    return (p == 16'd1080) || (p == 16'd4444) || (p == 16'd5555) || (p == 16'd6667) ||
           (p == 16'd6666) || (p == 16'd8888) || (p == 16'd9999) || (p == 16'd12345) ||
           (p == 16'd31337);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == TALLY_MAX) ? v : v + 16'd1;
  endfunction

  // Time moved forward by less than half the wrap range.
  function automatic logic later_second(input logic [31:0] now, input logic [31:0] then_s);
    logic [31:0] d;
    d = now - then_s;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ===== sv/packet_threat_classifier.sv =====
// ----------------------------------------------------------------------------
// packet_threat_classifier
// Seven-detector threat classifier for packet headers.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one packet header per beat; m_axis returns one verdict
//   beat per header, in order. Configuration registers are written through
//   cfg_we_i / cfg_index_i / cfg_wdata_i while no header is in flight.
// Processing:
//   The block takes one header at a time. The time a header costs grows
//   with F, the largest fill of the four source tables (a linear search
//   reads one entry at a time from each table RAM), and with P, the number
//   of ports held for the source in the scan table (the port list RAM is
//   also searched one entry at a time). With empty tables both searches
//   are skipped.
// Reset:
//   Fills, the ICMP tracker and registers go to their defaults at once; the
//   table RAMs are not cleared, entries beyond a fill are never looked at.
// Stall:
//   A verdict waits in the output register; the next header is taken and
//   processed, and only its commit holds until the register is free.
// ----------------------------------------------------------------------------
module packet_threat_classifier #(
  parameter int unsigned SOURCES          = 64,
  parameter int unsigned PORTS_PER_SOURCE = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_address[31:0], source port[47:32], destination port[63:48],
  // protocol[71:64], tcp_flags[77:72], now_seconds[109:78], zero pad[111:110]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // threat flag[0], threat_level[3:1], attack_kind[6:4], confidence_pct[13:7],
  // event_count[29:14], zero pad[31:30]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_wdata_i
);
  import ptc_pkg::*;

  ptc_ctl_t  ctl;
  ptc_stat_t stat;

  // Sequencer: accept, search, update, commit
  ptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Tables, detectors and the verdict register
  ptc_datapath #(
    .SOURCES          (SOURCES),
    .PORTS_PER_SOURCE (PORTS_PER_SOURCE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/ptc_ram.sv =====
// ----------------------------------------------------------------------------
// ptc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/ptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptc_ctrl
// Sequencer: source search, entry update, port list search, commit.
// ----------------------------------------------------------------------------
module ptc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptc_pkg::ptc_stat_t stat_i,
  output ptc_pkg::ptc_ctl_t  ctl_o
);
  import ptc_pkg::*;

  ptc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = ST_START;
        end
      end
      ST_START: state_d = stat_i.srch_empty ? ST_SLOT : ST_SRD;
      ST_SRD:   state_d = ST_SCMP;
      ST_SCMP: begin
        ctl_o.srch_cmp = 1'b1;
        state_d        = stat_i.srch_last ? ST_SLOT : ST_SRD;
      end
      ST_SLOT: begin
        ctl_o.slot_fix = 1'b1;
        state_d        = ST_ERD;
      end
      ST_ERD: begin
        ctl_o.rd_slot = 1'b1;
        state_d       = ST_EUPD;
      end
      ST_EUPD: begin
        ctl_o.ent_upd = 1'b1;
        state_d       = ST_PCHK;
      end
      ST_PCHK:  state_d = stat_i.port_skip ? ST_FIN : ST_PRD;
      ST_PRD:   state_d = ST_PCMP;
      ST_PCMP: begin
        ctl_o.port_cmp = 1'b1;
        state_d        = stat_i.port_last ? ST_FIN : ST_PRD;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          ctl_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/ptc_datapath.sv =====
// ----------------------------------------------------------------------------
// ptc_datapath
// Source tables, port lists, detector arithmetic and the result register.
// ----------------------------------------------------------------------------
module ptc_datapath #(
  parameter int unsigned SOURCES          = 64,
  parameter int unsigned PORTS_PER_SOURCE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptc_pkg::ptc_ctl_t  ctl_i,
  output ptc_pkg::ptc_stat_t stat_o,
  input  logic [111:0]       in_data_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_data_o
);
  import ptc_pkg::*;

  localparam int unsigned SW  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned FW  = $clog2(SOURCES + 1);
  localparam int unsigned TW  = $clog2(PORTS_PER_SOURCE + 1);
  localparam int unsigned CW  = (TW > 5) ? TW : 5;
  localparam int unsigned PD  = SOURCES * PORTS_PER_SOURCE;
  localparam int unsigned PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int unsigned EW  = 80;

  // Configuration
  logic [15:0] scan_window_q, syn_window_q, login_limit_q, flood_limit_q;
  logic [15:0] syn_limit_q, icmp_limit_q;
  logic [4:0]  scan_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_window_q <= SCAN_WINDOW_RST;
      syn_window_q  <= SYN_WINDOW_RST;
      scan_limit_q  <= SCAN_LIMIT_RST;
      login_limit_q <= LOGIN_LIMIT_RST;
      flood_limit_q <= FLOOD_LIMIT_RST;
      syn_limit_q   <= SYN_LIMIT_RST;
      icmp_limit_q  <= ICMP_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCAN_WINDOW: scan_window_q <= cfg_wdata_i;
        CFG_SYN_WINDOW:  syn_window_q  <= cfg_wdata_i;
        CFG_SCAN_LIMIT:  scan_limit_q  <= cfg_wdata_i[4:0];
        CFG_LOGIN_LIMIT: login_limit_q <= cfg_wdata_i;
        CFG_FLOOD_LIMIT: flood_limit_q <= cfg_wdata_i;
        CFG_SYN_LIMIT:   syn_limit_q   <= cfg_wdata_i;
        CFG_ICMP_LIMIT:  icmp_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured header
  logic [31:0] addr_q, now_q;
  logic [15:0] sport_q, dport_q;
  logic [7:0]  proto_q;
  logic [5:0]  flags_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      addr_q  <= in_data_i[31:0];
      sport_q <= in_data_i[47:32];
      dport_q <= in_data_i[63:48];
      proto_q <= in_data_i[71:64];
      flags_q <= in_data_i[77:72];
      now_q   <= in_data_i[109:78];
    end
  end

  logic tcp, syn, ack;
  logic [TABLES-1:0] en;
  assign tcp = (proto_q == PROTO_TCP);
  assign syn = flags_q[0];
  assign ack = flags_q[1];
  always_comb begin
    en          = '0;
    en[T_SCAN]  = tcp && syn;
    en[T_LOGIN] = tcp && syn && login_port_hit(dport_q);
    en[T_FLOOD] = 1'b1;
    en[T_SYN]   = tcp && syn && !ack;
  end

  // Source search
  logic [SW-1:0]     k_q;
  logic [FW-1:0]     fill_q  [TABLES];
  logic [SW-1:0]     slot_q  [TABLES];
  logic [TABLES-1:0] hit_q, found_q, created_q;
  logic [EW-1:0]     ent_rdata [TABLES];
  logic [EW-1:0]     ent_wdata [TABLES];
  logic [TABLES-1:0] ent_we;
  logic [FW-1:0]     max_fill;

  always_comb begin
    max_fill = fill_q[0];
    for (int t = 1; t < TABLES; t++) begin
      if (fill_q[t] > max_fill) max_fill = fill_q[t];
    end
  end

  assign stat_o.srch_empty = (max_fill == '0);
  assign stat_o.srch_last  = ((FW'(k_q) + FW'(1)) >= max_fill);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLES; t++) fill_q[t] <= '0;
    end else if (ctl_i.slot_fix) begin
      for (int t = 0; t < TABLES; t++) begin
        if (en[t] && !hit_q[t] && (fill_q[t] < FW'(SOURCES))) fill_q[t] <= fill_q[t] + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      k_q   <= '0;
      hit_q <= '0;
    end else if (ctl_i.srch_cmp) begin
      k_q <= k_q + SW'(1);
      for (int t = 0; t < TABLES; t++) begin
        if (!hit_q[t] && (FW'(k_q) < fill_q[t]) && (ent_rdata[t][79:48] == addr_q)) begin
          hit_q[t]  <= 1'b1;
          slot_q[t] <= k_q;
        end
      end
    end else if (ctl_i.slot_fix) begin
      for (int t = 0; t < TABLES; t++) begin
        created_q[t] <= !hit_q[t] && (fill_q[t] < FW'(SOURCES));
        found_q[t]   <= hit_q[t] || (fill_q[t] < FW'(SOURCES));
        if (!hit_q[t]) slot_q[t] <= fill_q[t][SW-1:0];
      end
    end
  end

  for (genvar g = 0; g < TABLES; g++) begin : g_tbl
    ptc_ram #(.WIDTH(EW), .DEPTH(SOURCES)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ent_we[g]),
      .waddr_i (slot_q[g]),
      .wdata_i (ent_wdata[g]),
      .raddr_i (ctl_i.rd_slot ? slot_q[g] : k_q),
      .rdata_o (ent_rdata[g])
    );
  end

  // Per-entry window arithmetic, valid in the update cycle
  logic [31:0] cur_time  [TABLES];
  logic [15:0] cur_tally [TABLES];
  logic [31:0] win_time  [TABLES];
  logic [15:0] win_tally [TABLES];
  logic        flood_later, flood_fire;
  logic [31:0] flood_time_n;
  logic [15:0] flood_tally_n;

  always_comb begin
    for (int t = 0; t < TABLES; t++) begin
      cur_time[t]  = created_q[t] ? now_q : ent_rdata[t][47:16];
      cur_tally[t] = created_q[t] ? 16'd0 : ent_rdata[t][15:0];
      if ((now_q - cur_time[t]) > {16'd0, (t == T_SYN) ? syn_window_q : scan_window_q}) begin
        win_time[t]  = now_q;
        win_tally[t] = 16'd0;
      end else begin
        win_time[t]  = cur_time[t];
        win_tally[t] = cur_tally[t];
      end
    end
    flood_later   = later_second(now_q, cur_time[T_FLOOD]);
    flood_fire    = flood_later && (cur_tally[T_FLOOD] > flood_limit_q);
    flood_time_n  = flood_later ? now_q : cur_time[T_FLOOD];
    flood_tally_n = flood_later ? (flood_fire ? 16'd0 : 16'd1) : sat_inc(cur_tally[T_FLOOD]);
  end

  // Detector outcomes held until commit
  logic          brute_q, flood_q, null_q, synf_q, port_q, icmp_q;
  logic [15:0]   brute_cnt_q, flood_cnt_q, syn_cnt_q, icmp_cnt_q;
  logic [31:0]   scan_time_q;
  logic [TW-1:0] scan_total_q;
  logic [TW-1:0] j_q;
  logic          seen_q;
  logic [15:0]   login_n, syn_n;
  logic [15:0]   port_rdata;

  assign login_n = sat_inc(win_tally[T_LOGIN]);
  assign syn_n   = sat_inc(win_tally[T_SYN]);

  // ICMP tracker
  logic [31:0] icmp_src_q, icmp_sec_q;
  logic [15:0] icmp_tally_q;
  logic        icmp_valid_q;
  logic        icmp_restart;
  logic [15:0] icmp_tally_n;

  assign icmp_restart = !icmp_valid_q || (icmp_src_q != addr_q) ||
                        later_second(now_q, icmp_sec_q);
  assign icmp_tally_n = sat_inc(icmp_restart ? 16'd0 : icmp_tally_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icmp_src_q   <= '0;
      icmp_sec_q   <= '0;
      icmp_tally_q <= '0;
      icmp_valid_q <= 1'b0;
    end else if (ctl_i.ent_upd && (proto_q == PROTO_ICMP)) begin
      icmp_tally_q <= icmp_tally_n;
      if (icmp_restart) begin
        icmp_src_q   <= addr_q;
        icmp_sec_q   <= now_q;
        icmp_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_upd) begin
      brute_q      <= en[T_LOGIN] && found_q[T_LOGIN] && (login_n > login_limit_q);
      brute_cnt_q  <= login_n;
      flood_q      <= found_q[T_FLOOD] && flood_fire;
      flood_cnt_q  <= cur_tally[T_FLOOD];
      null_q       <= tcp && (flags_q == 6'd0);
      synf_q       <= en[T_SYN] && found_q[T_SYN] && (syn_n > syn_limit_q);
      syn_cnt_q    <= syn_n;
      port_q       <= is_bad_port(dport_q) || is_bad_port(sport_q);
      icmp_q       <= (proto_q == PROTO_ICMP) && (icmp_tally_n > icmp_limit_q);
      icmp_cnt_q   <= icmp_tally_n;
      scan_time_q  <= win_time[T_SCAN];
      scan_total_q <= win_tally[T_SCAN][TW-1:0];
      j_q          <= '0;
      seen_q       <= 1'b0;
    end else if (ctl_i.port_cmp) begin
      j_q <= j_q + TW'(1);
      if (port_rdata == dport_q) seen_q <= 1'b1;
    end
  end

  // Port lists
  logic [PAW-1:0] port_base;
  logic           port_we;
  logic           scan_live, port_add;
  logic [TW-1:0]  scan_total_f;

  assign port_base = PAW'(slot_q[T_SCAN] * PORTS_PER_SOURCE);
  assign scan_live = en[T_SCAN] && found_q[T_SCAN];
  assign port_add  = !seen_q && (scan_total_q < TW'(PORTS_PER_SOURCE));
  assign scan_total_f = port_add ? scan_total_q + TW'(1) : scan_total_q;
  assign port_we   = ctl_i.fin && scan_live && port_add;

  assign stat_o.port_skip = !scan_live || (scan_total_q == '0);
  assign stat_o.port_last = ((j_q + TW'(1)) >= scan_total_q);

  ptc_ram #(.WIDTH(16), .DEPTH(PD)) u_ports (
    .clk_i   (clk_i),
    .we_i    (port_we),
    .waddr_i (port_base + PAW'(scan_total_q)),
    .wdata_i (dport_q),
    .raddr_i (port_base + PAW'(j_q)),
    .rdata_o (port_rdata)
  );

  // Entry writes: detectors in the update cycle, scan at commit
  always_comb begin
    ent_we          = '0;
    ent_we[T_SCAN]  = ctl_i.fin && scan_live;
    ent_we[T_LOGIN] = ctl_i.ent_upd && en[T_LOGIN] && found_q[T_LOGIN];
    ent_we[T_FLOOD] = ctl_i.ent_upd && found_q[T_FLOOD];
    ent_we[T_SYN]   = ctl_i.ent_upd && en[T_SYN] && found_q[T_SYN];
    ent_wdata[T_SCAN]  = {addr_q, scan_time_q, 16'(scan_total_f)};
    ent_wdata[T_LOGIN] = {addr_q, win_time[T_LOGIN], login_n};
    ent_wdata[T_FLOOD] = {addr_q, flood_time_n, flood_tally_n};
    ent_wdata[T_SYN]   = {addr_q, win_time[T_SYN], syn_n};
  end

  // Severity merge: strictly higher level wins, earlier detector on a tie
  logic [2:0]  lvl, kind;
  logic [6:0]  conf;
  logic [15:0] cnt;

  always_comb begin
    lvl  = LVL_NONE;
    kind = KIND_NONE;
    conf = '0;
    cnt  = '0;
    if (scan_live && (CW'(scan_total_f) > CW'(scan_limit_q))) begin
      lvl = LVL_HIGH; kind = KIND_SCAN; conf = CONF_SCAN; cnt = 16'(scan_total_f);
    end
    if (brute_q && (LVL_HIGH > lvl)) begin
      lvl = LVL_HIGH; kind = KIND_BRUTE; conf = CONF_BRUTE; cnt = brute_cnt_q;
    end
    if (flood_q && (LVL_CRITICAL > lvl)) begin
      lvl = LVL_CRITICAL; kind = KIND_FLOOD; conf = CONF_FLOOD; cnt = flood_cnt_q;
    end
    if (null_q && (LVL_MEDIUM > lvl)) begin
      lvl = LVL_MEDIUM; kind = KIND_NULL; conf = CONF_NULL; cnt = '0;
    end
    if (synf_q && (LVL_CRITICAL > lvl)) begin
      lvl = LVL_CRITICAL; kind = KIND_SYN; conf = CONF_SYN; cnt = syn_cnt_q;
    end
    if (port_q && (LVL_MEDIUM > lvl)) begin
      lvl = LVL_MEDIUM; kind = KIND_PORT; conf = CONF_PORT; cnt = '0;
    end
    if (icmp_q && (LVL_HIGH > lvl)) begin
      lvl = LVL_HIGH; kind = KIND_ICMP; conf = CONF_ICMP; cnt = icmp_cnt_q;
    end
  end

  // Result register
  logic        out_valid_q;
  logic [31:0] out_data_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      out_data_q <= {2'b00, cnt, conf, kind, lvl, (lvl != LVL_NONE)};
    end
  end

endmodule

// ===== sv/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_threat_classifier_defines.svh"

module ptc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);

  // Hold a stalled verdict beat
  `PTC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled verdict changed")

  // One header at a time: no accept right after an accept
  `PTC_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "header taken while busy")

  // Threat flag follows the level
  `PTC_ASSERT(a_flag_level, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] != 3'd0)), "threat flag mismatch")

  // Quiet verdict carries all zero fields
  `PTC_ASSERT(a_quiet_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[29:4] == 26'd0, "quiet verdict not zero")

endmodule

bind packet_threat_classifier ptc_checker u_ptc_checker (.*);
